@@ design/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the running status writer.
// Each macro expands to one labeled concurrent assertion on a clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, expr) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (expr)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds on the next clock edge.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/mers_pkg.sv @@
// Package for the MIDI event running status writer.
// Holds the transaction types, the queue command type and shared constants.
`timescale 1ns / 1ps
`default_nettype none

package mers_pkg;

  localparam int unsigned DeltaWidth = 28;
  localparam int unsigned DataWidth  = 7;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] DATA_MASK  = 8'h7F;
  localparam logic [7:0] STATUS_BIT = 8'h80;

  // Channel override reset value: keep each event's own channel.
  localparam logic [4:0] OVERRIDE_KEEP = 5'd16;

  // Message types (high nibble of the status byte).
  localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
  localparam logic [3:0] TYPE_PROGRAM   = 4'hC;
  localparam logic [3:0] TYPE_CHAN_PRES = 4'hD;
  localparam logic [3:0] TYPE_SYSTEM    = 4'hF;

  typedef struct packed {
    logic [DeltaWidth-1:0] delta_ticks;
    logic [7:0]            status_byte;
    logic [DataWidth-1:0]  first_data;
    logic [DataWidth-1:0]  second_data;
    logic                  new_track;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  // One classified event, ready to be serialized.
  typedef struct packed {
    logic [DeltaWidth-1:0] delta;
    logic [1:0]            top_group;
    logic [7:0]            status;
    logic                  send_status;
    logic [DataWidth-1:0]  d1;
    logic [DataWidth-1:0]  d2;
    logic                  has_d2;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/mers_front.sv @@
// Front end: accepts events, applies override and note-off rewrite, tracks running status.
// Depends on mers_pkg; feeds classified commands to mers_queue.
`timescale 1ns / 1ps
`default_nettype none

module mers_front import mers_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [4:0] channel_override;
  logic [7:0] sent_status;
  logic       status_known;

  logic [7:0] status_in;
  logic [3:0] msg_type;
  logic [7:0] status_ovr;
  logic [7:0] status_fin;
  logic       known_eff;
  logic       is_system;
  logic       send;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_override <= OVERRIDE_KEEP;
    end else if (cfg_valid) begin
      channel_override <= cfg_data;
    end
  end

  // Classify the incoming event.
  always_comb begin
    status_in = in_data.status_byte | STATUS_BIT;
    msg_type  = status_in[7:4];
    is_system = (msg_type == TYPE_SYSTEM);
    known_eff = status_known && !in_data.new_track;

    status_ovr = status_in;
    if (!channel_override[4]) begin
      status_ovr = {msg_type, channel_override[3:0]};
    end
    status_fin = status_ovr;
    if (msg_type == TYPE_NOTE_OFF) begin
      status_fin = {TYPE_NOTE_ON, status_ovr[3:0]};
    end
    if (is_system) begin
      status_fin = status_in;
    end

    send = is_system || !known_eff || (status_fin != sent_status);

    q_cmd.delta = in_data.delta_ticks;
    if (in_data.delta_ticks[27:21] != '0) begin
      q_cmd.top_group = 2'd3;
    end else if (in_data.delta_ticks[20:14] != '0) begin
      q_cmd.top_group = 2'd2;
    end else if (in_data.delta_ticks[13:7] != '0) begin
      q_cmd.top_group = 2'd1;
    end else begin
      q_cmd.top_group = 2'd0;
    end
    q_cmd.status      = status_fin;
    q_cmd.send_status = send;
    q_cmd.d1          = in_data.first_data;
    q_cmd.d2          = (msg_type == TYPE_NOTE_OFF) ? '0 : in_data.second_data;
    q_cmd.has_d2      = !is_system && (msg_type != TYPE_PROGRAM) &&
                        (msg_type != TYPE_CHAN_PRES);
  end

  // Running status bookkeeping, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_status  <= '0;
      status_known <= 1'b0;
    end else if (q_push) begin
      if (is_system) begin
        status_known <= 1'b0;
      end else begin
        sent_status  <= status_fin;
        status_known <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/mers_queue.sv @@
// Short command queue between the front end and the byte serializer.
// Depends on mers_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module mers_queue import mers_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire cmd_t                     push_cmd,
  output logic                          full,
  input  wire logic                     pop,
  output logic                          head_valid,
  output cmd_t                          head_cmd,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
  localparam logic [$clog2(DEPTH+1)-1:0] CountFull = ($clog2(DEPTH+1))'(DEPTH);

  cmd_t                entries [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;

  assign full       = (count == CountFull);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/mers_back.sv @@
// Back end: serializes one command into delta, status and data bytes.
// Depends on mers_pkg; drives the registered output channel.
`timescale 1ns / 1ps
`default_nettype none

module mers_back import mers_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire cmd_t head_cmd,
  output logic      pop,
  output logic      busy,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam logic [1:0] PH_DELTA  = 2'd0;
  localparam logic [1:0] PH_STATUS = 2'd1;
  localparam logic [1:0] PH_DATA1  = 2'd2;
  localparam logic [1:0] PH_DATA2  = 2'd3;

  cmd_t       cmd;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [1:0] grp;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       can_load;
  logic       emit;
  logic [6:0] group_bits;

  assign can_load = !out_valid || out_ready;
  assign emit     = busy && can_load;
  assign pop      = head_valid && (!busy || (emit && cur_last));

  // Pick the current byte and the phase after it.
  always_comb begin
    case (grp)
      2'd0:    group_bits = cmd.delta[6:0];
      2'd1:    group_bits = cmd.delta[13:7];
      2'd2:    group_bits = cmd.delta[20:14];
      default: group_bits = cmd.delta[27:21];
    endcase
    cur_byte   = '0;
    cur_last   = 1'b0;
    phase_next = phase;
    case (phase)
      PH_DELTA: begin
        cur_byte = {(grp != 2'd0), group_bits};
        if (grp == 2'd0) begin
          phase_next = cmd.send_status ? PH_STATUS : PH_DATA1;
        end
      end
      PH_STATUS: begin
        cur_byte   = cmd.status;
        phase_next = PH_DATA1;
      end
      PH_DATA1: begin
        cur_byte   = {1'b0, cmd.d1};
        cur_last   = !cmd.has_d2;
        phase_next = PH_DATA2;
      end
      PH_DATA2: begin
        cur_byte = {1'b0, cmd.d2};
        cur_last = 1'b1;
      end
      default: begin
        cur_byte = '0;
      end
    endcase
  end

  // Command register and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_DELTA;
      grp   <= '0;
    end else if (pop) begin
      busy  <= 1'b1;
      phase <= PH_DELTA;
      grp   <= head_cmd.top_group;
    end else if (emit) begin
      if (cur_last) begin
        busy <= 1'b0;
      end else if (phase == PH_DELTA && grp != 2'd0) begin
        grp <= grp - 1'b1;
      end else begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
    end
  end

  // Output register: a byte waits here while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_byte  <= cur_byte;
      out_data.last_byte <= cur_last;
    end
  end

endmodule

`default_nettype wire

@@ design/midi_event_running_status_writer.sv @@
// MIDI event running status writer: encodes channel events as SMF track event bytes.
// Usage: the input channel (in_valid/in_ready/in_data) takes one channel event per
// transaction: delta time, status byte, two data bytes and a new-track flag.
// The output channel (out_valid/out_ready/out_data) gives one byte per transaction,
// with last_byte set on the final byte of each event: delta as a 1 to 4 byte
// variable-length quantity, the status byte only when it differs from the last one
// sent, then one or two data bytes. Note-off leaves as note-on with velocity 0.
// The cfg channel writes channel_override; cfg_ready is always high.
// Throughput: one byte per cycle from the serializer while the receiver is ready;
// an event has 2 to 7 bytes. The front end accepts while the command queue
// (QUEUE_DEPTH entries) has room, which it does while earlier bytes drain.
// Reset clears running status and sets the override to keep each event's channel.
// When the receiver stalls, the output byte holds, the serializer waits, and
// once the queue is full in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module midi_event_running_status_writer import mers_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data
);

  localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);

  logic                  q_full;
  logic                  q_push;
  cmd_t                  q_cmd;
  logic                  q_pop;
  logic                  q_head_valid;
  cmd_t                  q_head_cmd;
  logic [CountWidth-1:0] q_count;
  logic                  back_busy;

  mers_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mers_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .count      (q_count)
  );

  mers_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .busy       (back_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // The queue never holds more commands than it has entries.
  `ASSERT_ALWAYS(a_queue_bound, clk, rst, q_count <= CountWidth'(QUEUE_DEPTH))
  // While a command waits, the serializer is busy on the next cycle.
  `ASSERT_NEXT(a_queue_drains, clk, rst, q_head_valid, back_busy)
  // The final byte of an event is always a data byte.
  `ASSERT_ALWAYS(a_last_is_data, clk, rst, !(out_valid && out_data.last_byte) || !out_data.out_byte[7])

endmodule

`default_nettype wire

@@ tb/sv/track_byte_checker.sv @@
`timescale 1ns / 1ps
// Checker for the MIDI event running status writer: watches the config, event and
// byte channels, predicts the encoded track bytes of each event and compares them.
// Depends on mers_pkg for the transaction types and the message type codes.

module track_byte_checker import mers_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_t        in_data,
  output int         error_count,
  output int         bytes_outstanding,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_t       out_data
);

  // Shadow of the block's state and its one register.
  logic [4:0] forced_channel;
  logic [7:0] last_status;
  logic       status_held;
  int         mismatches;
  out_t       expected_bytes[$];

  function automatic void push_byte(input logic [7:0] value);
    out_t item;
    item.out_byte  = value;
    item.last_byte = 1'b0;
    expected_bytes.push_back(item);
  endfunction

  // Appends the bytes of one track event and updates the running status.
  function automatic void encode_event(input in_t ev);
    logic [7:0] status;
    logic [3:0] msg_type;
    logic [6:0] velocity;
    out_t       tail;
    int         groups;
    status   = ev.status_byte | STATUS_BIT;
    msg_type = status[7:4];
    velocity = ev.second_data;
    groups   = 1;
    if (ev.new_track) begin
      status_held = 1'b0;
    end
    // Delta time as a variable-length quantity, most significant group first.
    while (groups < 4 && (ev.delta_ticks >> (7 * groups)) != 0) begin
      groups++;
    end
    for (int g = groups - 1; g >= 0; g--) begin
      push_byte({(g != 0), ev.delta_ticks[7*g +: 7]});
    end
    if (msg_type == TYPE_SYSTEM) begin
      // System messages always carry their status and cancel running status.
      push_byte(status);
      push_byte({1'b0, ev.first_data});
      status_held = 1'b0;
    end else begin
      // The override goes first, so a note-off lands on the forced channel.
      if (forced_channel < OVERRIDE_KEEP) begin
        status[3:0] = forced_channel[3:0];
      end
      if (msg_type == TYPE_NOTE_OFF) begin
        status[7:4] = TYPE_NOTE_ON;
        msg_type    = TYPE_NOTE_ON;
        velocity    = '0;
      end
      if (!status_held || status != last_status) begin
        push_byte(status);
        last_status = status;
        status_held = 1'b1;
      end
      push_byte({1'b0, ev.first_data});
      if (msg_type != TYPE_PROGRAM && msg_type != TYPE_CHAN_PRES) begin
        push_byte({1'b0, velocity});
      end
    end
    tail = expected_bytes.pop_back();
    tail.last_byte = 1'b1;
    expected_bytes.push_back(tail);
  endfunction

  // Each edge: register writes, then the output byte, then the new event.
  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      forced_channel = OVERRIDE_KEEP;
      last_status    = '0;
      status_held    = 1'b0;
      mismatches     = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        forced_channel = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, got byte %02h last %0b",
                   $time, out_data.out_byte, out_data.last_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (want.out_byte !== out_data.out_byte) begin
            $display("%0t: out_byte mismatch: expected %02h, got %02h",
                     $time, want.out_byte, out_data.out_byte);
            mismatches++;
          end
          if (want.last_byte !== out_data.last_byte) begin
            $display("%0t: last_byte mismatch: expected %0b, got %0b",
                     $time, want.last_byte, out_data.last_byte);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        encode_event(in_data);
      end
    end
    error_count       <= mismatches;
    bytes_outstanding <= expected_bytes.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the running status writer testbench: clock, reset, event and config
// stimulus, receiver stalls, watchdog and verdict. Uses mers_pkg and track_byte_checker.

module tb_top;
  import mers_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int PHASE_EVENTS   = 30;

  // Channel message types that the package does not name.
  localparam logic [3:0] TYPE_POLY_PRES  = 4'hA;
  localparam logic [3:0] TYPE_CONTROL    = 4'hB;
  localparam logic [3:0] TYPE_PITCH_BEND = 4'hE;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;

  int         error_count;
  int         bytes_outstanding;
  int         idle_cycles = 0;
  bit         tx_gaps     = 1'b1;
  bit         rx_gaps     = 1'b1;
  bit         hold_req    = 1'b0;
  bit         hold_served = 1'b0;
  logic [7:0] recent_status = {TYPE_NOTE_ON, 4'h0};
  logic [4:0] override_plan[5];

  always #5 clk = ~clk;

  midi_event_running_status_writer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  track_byte_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .error_count      (error_count),
    .bytes_outstanding(bytes_outstanding),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

  function automatic in_t make_event(input logic [27:0] delta, input logic [7:0] status,
                                     input logic [6:0] d1, input logic [6:0] d2,
                                     input logic fresh_track);
    in_t ev;
    ev.delta_ticks = delta;
    ev.status_byte = status;
    ev.first_data  = d1;
    ev.second_data = d2;
    ev.new_track   = fresh_track;
    return ev;
  endfunction

  // Mostly runs of one status so running status is exercised, plus noise.
  function automatic in_t random_event();
    in_t ev;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      ev.delta_ticks = 28'($urandom_range(0, 127));
    end else if (pick < 65) begin
      ev.delta_ticks = 28'($urandom_range(128, 16383));
    end else if (pick < 80) begin
      ev.delta_ticks = 28'($urandom_range(16384, 2097151));
    end else begin
      ev.delta_ticks = 28'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      ev.status_byte = recent_status;
    end else if (pick < 85) begin
      ev.status_byte = 8'($urandom_range(8'h80, 8'hEF));
    end else if (pick < 93) begin
      ev.status_byte = 8'($urandom_range(8'hF0, 8'hFF));
    end else begin
      ev.status_byte = 8'($urandom);
    end
    if (ev.status_byte[7] && ev.status_byte[7:4] != TYPE_SYSTEM) begin
      recent_status = ev.status_byte;
    end
    ev.first_data  = 7'($urandom);
    ev.second_data = 7'($urandom);
    ev.new_track   = ($urandom_range(0, 15) == 0);
    return ev;
  endfunction

  // Offers one event and holds it until the transaction completes.
  task automatic send_event(input in_t ev);
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted byte has come out.
  task automatic drain_track();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_override(input logic [4:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: ready runs, short stalls, and one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles in which no transaction completes on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    override_plan[0] = 5'd0;
    override_plan[1] = 5'd15;
    override_plan[2] = 5'd31;
    override_plan[3] = 5'($urandom);
    override_plan[4] = OVERRIDE_KEEP;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed events with the override at its reset value.
    send_event(make_event(28'd0, {TYPE_NOTE_ON, 4'h0}, 7'd0, 7'd127, 1'b1));
    send_event(make_event(28'd127, {TYPE_NOTE_ON, 4'h0}, 7'd127, 7'd0, 1'b0));
    // Note-off on the same channel shares the note-on running status.
    send_event(make_event(28'd128, {TYPE_NOTE_OFF, 4'h0}, 7'd60, 7'd55, 1'b0));
    send_event(make_event(28'd16383, {TYPE_NOTE_OFF, 4'h5}, 7'd1, 7'd2, 1'b0));
    send_event(make_event(28'd16384, {TYPE_POLY_PRES, 4'h3}, 7'd64, 7'd127, 1'b0));
    send_event(make_event(28'd2097151, {TYPE_CONTROL, 4'h3}, 7'd7, 7'd100, 1'b0));
    send_event(make_event(28'd2097152, {TYPE_PROGRAM, 4'h3}, 7'd5, 7'd99, 1'b0));
    send_event(make_event(28'hFFFFFFF, {TYPE_CHAN_PRES, 4'h3}, 7'd7, 7'd9, 1'b0));
    send_event(make_event(28'd1, {TYPE_PITCH_BEND, 4'h3}, 7'd0, 7'd64, 1'b0));
    send_event(make_event(28'd2, {TYPE_PITCH_BEND, 4'h3}, 7'd1, 7'd64, 1'b0));
    // A system message cancels running status, so the next status is resent.
    send_event(make_event(28'd3, {TYPE_SYSTEM, 4'h0}, 7'd127, 7'd55, 1'b0));
    send_event(make_event(28'd4, {TYPE_PITCH_BEND, 4'h3}, 7'd2, 7'd3, 1'b0));
    send_event(make_event(28'd5, {TYPE_PITCH_BEND, 4'h3}, 7'd4, 7'd5, 1'b1));
    // Status bytes with bit 7 clear are taken as if it were set.
    send_event(make_event(28'd6, 8'h00, 7'd3, 7'd4, 1'b0));
    send_event(make_event(28'd7, 8'h7F, 7'd1, 7'd1, 1'b0));
    send_event(make_event(28'd8, 8'h4C, 7'd9, 7'd8, 1'b0));
    send_event(make_event(28'd9, {TYPE_SYSTEM, 4'hF}, 7'd0, 7'd127, 1'b0));
    send_event(make_event(28'd10, {TYPE_NOTE_ON, 4'hF}, 7'd127, 7'd127, 1'b0));
    send_event(make_event(28'd11, {TYPE_NOTE_OFF, 4'hF}, 7'd42, 7'd99, 1'b0));
    drain_track();

    // Random phases, one per override setting; the block is idle at each write.
    for (int phase = 0; phase < 5; phase++) begin
      write_override(override_plan[phase]);
      tx_gaps = (phase != 1 && phase != 4);
      rx_gaps = (phase != 4);
      if (phase == 1) begin
        hold_req = 1'b1;
      end
      for (int k = 0; k < PHASE_EVENTS; k++) begin
        send_event(random_event());
      end
      drain_track();
    end

    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mers_pkg.sv
design/mers_front.sv
design/mers_queue.sv
design/mers_back.sv
design/midi_event_running_status_writer.sv
tb/sv/track_byte_checker.sv
tb/sv/tb_top.sv
